// ===== rtl/dva_pkg.sv =====
`default_nettype none
package dva_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DEPOSIT = 2'd0,
    ST_VACUUM  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_BIN_X     = 3'd3;
  localparam logic [2:0] REG_BIN_Y     = 3'd4;
  localparam logic [2:0] REG_BIN_Z     = 3'd5;
  localparam logic [2:0] REG_DEN_FLOOR = 3'd6;

  // Datapath operations selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_AXIS,
    OP_DIV_DOSE,
    OP_MUL,
    OP_READ,
    OP_WRITE,
    OP_CLEAR
  } dp_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [1:0] mul_step;
    logic       div_start;
    logic       clr_valid;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_read;
    logic vacuum;
    logic outside;
    logic div_done;
    logic clr_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/dva_ram.sv =====
`default_nettype none
module dva_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/dva_div.sv =====
`default_nettype none
module dva_div #(
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_r[DW-1:0], quo_r[NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign quo     = quo_r;
  assign done    = busy_r && (cnt_r == CW'(0));

  // Restoring division, one quotient bit each cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      quo_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r && cnt_r != CW'(0)) begin
      cnt_r <= cnt_r - CW'(1);
      if (!diff[DW]) begin
        rem_r <= diff;
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dva_datapath.sv =====
`default_nettype none
module dva_datapath #(
  parameter int NBX = 16,
  parameter int NBY = 16,
  parameter int NBZ = 16,
  parameter int AW  = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             in_command,
  input  wire logic [31:0]      in_energy,
  input  wire logic [31:0]      in_pos_x,
  input  wire logic [31:0]      in_pos_y,
  input  wire logic [31:0]      in_pos_z,
  input  wire logic [15:0]      in_density,
  input  wire logic [11:0]      in_read_index,
  input  wire dva_pkg::dp_cmd_t cmd,
  output dva_pkg::dp_sts_t      sts,
  output logic [1:0]            res_status,
  output logic [11:0]           res_index,
  output logic [63:0]           res_dose
);

  localparam int DEPTH = NBX * NBY * NBZ;

  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [12:0] bin_x_r, bin_y_r, bin_z_r;
  logic [15:0] floor_r;

  logic        cmd_r;
  logic [31:0] energy_r;
  logic [32:0] diff_r [3];
  logic [15:0] den_r;
  logic [11:0] ridx_r;
  logic [7:0]  bin_r [3];
  logic [2:0]  outside_r;
  logic [57:0] prod_r;
  logic [63:0] delta_r;
  logic [AW:0] lin_r;
  logic [1:0]  st_r;
  logic [11:0] oidx_r;
  logic [63:0] odose_r;

  // Address of the clearing pass that zeroes the store after reset.
  logic [AW-1:0] clr_addr_r;

  logic          dstart;
  logic [63:0]   dnum;
  logic [57:0]   dden;
  logic          ddone;
  logic [63:0]   dquo;
  logic [12:0]   axis_bin;
  logic [63:0]   ram_q;
  logic [63:0]   cur;
  logic [63:0]   sum;
  logic          ovf;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;

  always_comb begin
    case (cmd.axis)
      2'd0:    axis_bin = bin_x_r;
      2'd1:    axis_bin = bin_y_r;
      default: axis_bin = bin_z_r;
    endcase
  end

  assign dstart = cmd.div_start;
  always_comb begin
    if (cmd.op == dva_pkg::OP_DIV_DOSE) begin
      dnum = {energy_r, 32'd0};
      dden = prod_r;
    end else begin
      dnum = {31'd0, diff_r[cmd.axis]};
      dden = {45'd0, axis_bin};
    end
  end

  dva_div #(.NW(64), .DW(58)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  // The clearing pass writes zeros; otherwise only a deposit writes back.
  assign cur        = ram_q;
  assign {ovf, sum} = {1'b0, cur} + {1'b0, delta_r};
  assign ram_we     = (cmd.op == dva_pkg::OP_CLEAR) ||
                      ((cmd.op == dva_pkg::OP_WRITE) && !cmd_r);
  assign ram_waddr  = (cmd.op == dva_pkg::OP_CLEAR) ? clr_addr_r : lin_r[AW-1:0];
  assign ram_wdata  = (cmd.op == dva_pkg::OP_CLEAR) ? 64'd0 : (ovf ? '1 : sum);

  dva_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(lin_r[AW-1:0]), .rdata(ram_q)
  );

  assign sts.is_read  = cmd_r;
  assign sts.vacuum   = (den_r == 16'd0) || (den_r < floor_r);
  assign sts.outside  = |outside_r;
  assign sts.div_done = ddone;
  assign sts.clr_done = &clr_addr_r;

  assign res_status = st_r;
  assign res_index  = oidx_r;
  assign res_dose   = odose_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      bin_x_r <= 13'd16; bin_y_r <= 13'd16; bin_z_r <= 13'd16;
      floor_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dva_pkg::REG_ORIGIN_X:  org_x_r <= cfg_data;
        dva_pkg::REG_ORIGIN_Y:  org_y_r <= cfg_data;
        dva_pkg::REG_ORIGIN_Z:  org_z_r <= cfg_data;
        dva_pkg::REG_BIN_X:     bin_x_r <= cfg_data[12:0];
        dva_pkg::REG_BIN_Y:     bin_y_r <= cfg_data[12:0];
        dva_pkg::REG_BIN_Z:     bin_z_r <= cfg_data[12:0];
        dva_pkg::REG_DEN_FLOOR: floor_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clearing pass address, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.op == dva_pkg::OP_CLEAR) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Item registers and the per-step work.
  always_ff @(posedge clk) begin
    case (cmd.op)
      dva_pkg::OP_LOAD: begin
        cmd_r     <= in_command;
        energy_r  <= in_energy;
        den_r     <= in_density;
        ridx_r    <= in_read_index;
        diff_r[0] <= 33'(signed'(in_pos_x)) - 33'(org_x_r);
        diff_r[1] <= 33'(signed'(in_pos_y)) - 33'(org_y_r);
        diff_r[2] <= 33'(signed'(in_pos_z)) - 33'(org_z_r);
        outside_r <= '0;
        lin_r     <= '0;
      end
      dva_pkg::OP_DIV_AXIS: begin
        if (ddone) begin
          bin_r[cmd.axis] <= dquo[7:0];
          if (diff_r[cmd.axis][32] || axis_bin == 13'd0 ||
              dquo >= 64'(cmd.axis == 2'd0 ? NBX : cmd.axis == 2'd1 ? NBY : NBZ)) begin
            outside_r[cmd.axis] <= 1'b1;
          end
        end
      end
      dva_pkg::OP_MUL: begin
        case (cmd.mul_step)
          2'd0: begin
            prod_r <= 58'(den_r) * 58'(bin_x_r);
            lin_r  <= (AW+1)'(bin_r[0]) * (AW+1)'(NBY) + (AW+1)'(bin_r[1]);
          end
          2'd1: begin
            prod_r <= 58'(prod_r[28:0]) * 58'(bin_y_r);
            lin_r  <= (AW+1)'(lin_r * (AW+1)'(NBZ)) + (AW+1)'(bin_r[2]);
          end
          default: prod_r <= 58'(prod_r[41:0]) * 58'(bin_z_r);
        endcase
      end
      dva_pkg::OP_DIV_DOSE: begin
        if (ddone) delta_r <= dquo;
      end
      dva_pkg::OP_READ: begin
        lin_r <= (AW+1)'(ridx_r);
      end
      default: ;
    endcase
    // Result register.
    if (cmd.op == dva_pkg::OP_WRITE) begin
      if (cmd_r) begin
        st_r    <= dva_pkg::ST_READ;
        oidx_r  <= ridx_r;
        odose_r <= (32'(ridx_r) < 32'(DEPTH)) ? cur : 64'd0;
      end else begin
        st_r    <= dva_pkg::ST_DEPOSIT;
        oidx_r  <= 12'(lin_r);
        odose_r <= ovf ? '1 : sum;
      end
    end else if (cmd.clr_valid) begin
      st_r    <= sts.vacuum ? dva_pkg::ST_VACUUM : dva_pkg::ST_OUTSIDE;
      oidx_r  <= '0;
      odose_r <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dva_ctrl.sv =====
`default_nettype none
module dva_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire dva_pkg::dp_sts_t sts,
  output dva_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DAXIS, S_WAXIS, S_MUL, S_DDOSE, S_WDOSE,
    S_RADDR, S_RWAIT, S_UPDATE, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] mstep_r, mstep_nxt;
  logic       ovld_r, ovld_nxt;

  assign in_stall  = (state_r != S_IDLE) || ovld_r;
  assign out_valid = ovld_r;

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    mstep_nxt = mstep_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '{op: dva_pkg::OP_NONE, axis: axis_r, mul_step: mstep_r,
                  div_start: 1'b0, clr_valid: 1'b0};
    case (state_r)
      // Zero the store one entry per cycle after reset.
      S_CLEAR: begin
        cmd.op = dva_pkg::OP_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.op    = dva_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_nxt  = 2'd0;
        mstep_nxt = 2'd0;
        if (sts.is_read) begin
          cmd.op    = dva_pkg::OP_READ;
          state_nxt = S_RADDR;
        end else if (sts.vacuum) begin
          cmd.clr_valid = 1'b1;
          ovld_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DAXIS;
        end
      end
      S_DAXIS: begin
        cmd.op        = dva_pkg::OP_DIV_AXIS;
        cmd.div_start = 1'b1;
        state_nxt     = S_WAXIS;
      end
      S_WAXIS: begin
        cmd.op = dva_pkg::OP_DIV_AXIS;
        if (sts.div_done) begin
          if (axis_r == 2'd2) begin
            state_nxt = S_MUL;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DAXIS;
          end
        end
      end
      S_MUL: begin
        if (sts.outside) begin
          cmd.clr_valid = 1'b1;
          ovld_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.op    = dva_pkg::OP_MUL;
          mstep_nxt = mstep_r + 2'd1;
          if (mstep_r == 2'd2) state_nxt = S_DDOSE;
        end
      end
      S_DDOSE: begin
        cmd.op        = dva_pkg::OP_DIV_DOSE;
        cmd.div_start = 1'b1;
        state_nxt     = S_WDOSE;
      end
      S_WDOSE: begin
        cmd.op = dva_pkg::OP_DIV_DOSE;
        if (sts.div_done) state_nxt = S_RWAIT;
      end
      S_RADDR: state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_UPDATE;
      S_UPDATE: begin
        cmd.op    = dva_pkg::OP_WRITE;
        ovld_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      axis_r  <= '0;
      mstep_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      mstep_r <= mstep_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dose_voxel_accumulator.sv =====
`default_nettype none
// Voxel dose accumulator.
// Input channel in_*: one item is a deposit (command 0) or a read (command 1),
// accepted when in_valid is high and in_stall is low. Each item gives exactly
// one result on out_*, held until taken (out_valid high, out_stall low).
// A deposit is binned to a voxel by three 64-step divisions on one shared
// serial divider, then its dose increment is found by a fourth 64-step
// division of energy*2^32 by density times voxel volume; the voxel sum then
// saturates at all ones. Only one item is in flight; in_stall stays high
// until the result register is empty, so a stalled receiver holds the block
// with its result intact. Reset restores the configuration defaults and
// starts a clearing pass that writes zero to every store entry, one per
// cycle, during which in_stall stays high. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, as the
// block itself does not enforce this.
module dose_voxel_accumulator #(
  parameter int NUM_BINS_X = 16,
  parameter int NUM_BINS_Y = 16,
  parameter int NUM_BINS_Z = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_energy,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [15:0] in_density,
  input  wire logic [11:0] in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [11:0]      out_voxel_index,
  output logic [63:0]      out_dose_value
);

  localparam int AW = $clog2(NUM_BINS_X * NUM_BINS_Y * NUM_BINS_Z) < 1 ? 1 :
                      $clog2(NUM_BINS_X * NUM_BINS_Y * NUM_BINS_Z);

  dva_pkg::dp_cmd_t cmd;
  dva_pkg::dp_sts_t sts;

  dva_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  dva_datapath #(.NBX(NUM_BINS_X), .NBY(NUM_BINS_Y), .NBZ(NUM_BINS_Z), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_command(in_command), .in_energy(in_energy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_density(in_density), .in_read_index(in_read_index), .cmd(cmd), .sts(sts),
    .res_status(out_status), .res_index(out_voxel_index), .res_dose(out_dose_value)
  );

endmodule
`default_nettype wire

// ===== bench/dose_voxel_accumulator_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module dose_voxel_accumulator_tb;

  localparam int GRID_N = 16;
  localparam int STORE_SIZE = GRID_N * GRID_N * GRID_N;
  localparam logic COMMAND_DEPOSIT = 1'b0;
  localparam logic COMMAND_READ = 1'b1;
  // Index one past the register list; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    dva_pkg::status_t status;
    logic [11:0]      voxel;
    logic [63:0]      dose;
  } dose_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [31:0] in_energy = '0;
  logic [31:0] in_pos_x = '0;
  logic [31:0] in_pos_y = '0;
  logic [31:0] in_pos_z = '0;
  logic [15:0] in_density = '0;
  logic [11:0] in_read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [11:0] out_voxel_index;
  logic [63:0] out_dose_value;

  dose_voxel_accumulator dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the grid setup and the voxel sums.
  logic [31:0] grid_origin [3];
  logic [12:0] grid_bin [3];
  logic [15:0] vacuum_floor;
  logic [63:0] voxel_dose [STORE_SIZE];

  dose_result_t pending_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int deposits_seen = 0;
  int saturated_seen = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  bit quiet_receiver = 1'b0;

  // Returns 1 and the bin when the coordinate falls inside the grid on one axis.
  function automatic bit find_bin(input logic [31:0] pos, input logic [31:0] org,
                                  input logic [12:0] size, output logic [3:0] bin);
    longint diff;
    longint q;
    bin = '0;
    diff = longint'($signed(pos)) - longint'($signed(org));
    if (size == 0 || diff < 0) return 1'b0;
    q = diff / longint'(size);
    if (q >= GRID_N) return 1'b0;
    bin = q[3:0];
    return 1'b1;
  endfunction

  // Works out the result of one item and updates the shadow voxel sums.
  function automatic dose_result_t accumulate_dose(
      input logic cmd, input logic [31:0] energy, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [15:0] den,
      input logic [11:0] ridx);
    dose_result_t r;
    logic [3:0] bx, by, bz;
    logic [11:0] lin;
    logic [63:0] denom, delta, cur;
    r = '0;
    if (cmd == COMMAND_READ) begin
      r.status = dva_pkg::ST_READ;
      r.voxel = ridx;
      r.dose = voxel_dose[ridx];
      return r;
    end
    if (den == 0 || den < vacuum_floor) begin
      r.status = dva_pkg::ST_VACUUM;
      return r;
    end
    if (!find_bin(px, grid_origin[0], grid_bin[0], bx) ||
        !find_bin(py, grid_origin[1], grid_bin[1], by) ||
        !find_bin(pz, grid_origin[2], grid_bin[2], bz)) begin
      r.status = dva_pkg::ST_OUTSIDE;
      return r;
    end
    lin = {bx, by, bz};
    denom = 64'(den) * 64'(grid_bin[0]) * 64'(grid_bin[1]) * 64'(grid_bin[2]);
    delta = {energy, 32'h0} / denom;
    cur = voxel_dose[lin];
    if (cur > ~64'd0 - delta) cur = ~64'd0;
    else cur = cur + delta;
    voxel_dose[lin] = cur;
    r.status = dva_pkg::ST_DEPOSIT;
    r.voxel = lin;
    r.dose = cur;
    return r;
  endfunction

  // Offers one item, waits for its acceptance and queues its expected result.
  task automatic send_item(input logic cmd, input logic [31:0] energy,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [15:0] den,
                           input logic [11:0] ridx);
    dose_result_t expected;
    // Sender gaps between bursts; valid is already low here.
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_energy <= energy;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_density <= den;
    in_read_index <= ridx;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    expected = accumulate_dose(cmd, energy, px, py, pz, den, ridx);
    pending_results = {pending_results, expected};
    items_sent++;
    @(negedge clk);
    // Valid stays up within a burst and drops at its end.
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Closes an open burst, then waits for every outstanding result.
  task automatic wait_drained();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Writes one register once the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dva_pkg::REG_ORIGIN_X: grid_origin[0] = value;
      dva_pkg::REG_ORIGIN_Y: grid_origin[1] = value;
      dva_pkg::REG_ORIGIN_Z: grid_origin[2] = value;
      dva_pkg::REG_BIN_X: grid_bin[0] = value[12:0];
      dva_pkg::REG_BIN_Y: grid_bin[1] = value[12:0];
      dva_pkg::REG_BIN_Z: grid_bin[2] = value[12:0];
      dva_pkg::REG_DEN_FLOOR: vacuum_floor = value[15:0];
      default: ;
    endcase
  endtask

  task automatic setup_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] bx,
                            input logic [31:0] by, input logic [31:0] bz,
                            input logic [31:0] dfloor);
    write_reg(dva_pkg::REG_ORIGIN_X, ox);
    write_reg(dva_pkg::REG_ORIGIN_Y, oy);
    write_reg(dva_pkg::REG_ORIGIN_Z, oz);
    write_reg(dva_pkg::REG_BIN_X, bx);
    write_reg(dva_pkg::REG_BIN_Y, by);
    write_reg(dva_pkg::REG_BIN_Z, bz);
    write_reg(dva_pkg::REG_DEN_FLOOR, dfloor);
  endtask

  // Picks a coordinate inside the grid on one axis when the bin size allows.
  function automatic logic [31:0] pos_in_grid(input int axis);
    int span;
    span = (grid_bin[axis] == 0) ? 64 : GRID_N * grid_bin[axis];
    return grid_origin[axis] + $urandom_range(0, span - 1);
  endfunction

  // One random item: mostly in-grid deposits, then reads and noise.
  task automatic send_random_item();
    int pick;
    logic [15:0] den;
    pick = $urandom_range(0, 99);
    den = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
          16'($urandom_range(vacuum_floor, 65535));
    if (pick < 70)
      send_item(COMMAND_DEPOSIT, $urandom, pos_in_grid(0), pos_in_grid(1),
                pos_in_grid(2), den, 12'($urandom));
    else if (pick < 85)
      send_item(COMMAND_READ, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                12'($urandom));
    else if (pick < 92)
      send_item(COMMAND_DEPOSIT, $urandom, pos_in_grid(0) + $urandom_range(0, 3) * 4096,
                pos_in_grid(1) - $urandom_range(0, 1) * 4096, pos_in_grid(2), den,
                12'($urandom));
    else
      send_item(COMMAND_DEPOSIT, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                12'($urandom));
  endtask

  // Reset values, the vacuum and outside cases, zero bins and ignored writes.
  task automatic test_special_cases();
    send_item(COMMAND_READ, 0, 0, 0, 0, 0, 12'd0);
    send_item(COMMAND_READ, '1, '1, '1, '1, '1, 12'hFFF);
    send_item(COMMAND_DEPOSIT, 32'd1000, 32'd5, 32'd20, 32'd255, 16'd0, 12'hFFF);
    send_item(COMMAND_DEPOSIT, '1, 32'd0, 32'd0, 32'd0, 16'd1, 12'd0);
    send_item(COMMAND_DEPOSIT, '1, 32'd255, 32'd255, 32'd255, 16'hFFFF, 12'd0);
    send_item(COMMAND_DEPOSIT, 32'd7, 32'd256, 32'd0, 32'd0, 16'd3, 12'd0);
    send_item(COMMAND_DEPOSIT, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd3, 12'd0);
    send_item(COMMAND_DEPOSIT, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'd3, 12'd0);
    send_item(COMMAND_READ, 0, 0, 0, 0, 0, 12'd0);
    send_item(COMMAND_READ, 0, 0, 0, 0, 0, 12'hFFF);
    // Vacuum wins over outside; floor of zero still skips zero density.
    write_reg(dva_pkg::REG_DEN_FLOOR, 32'd0);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'h8000_0000, 32'd0, 32'd0, 16'd0, 12'd0);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'd17, 32'd33, 32'd49, 16'd1, 12'd0);
    write_reg(dva_pkg::REG_BIN_Y, 32'd0);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'd0, 32'd0, 32'd0, 16'd1, 12'd0);
    write_reg(REG_UNUSED, 32'h0000_0001);
    write_reg(dva_pkg::REG_BIN_Y, 32'hFFFF_E010);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'd1, 32'd1, 32'd1, 16'd1, 12'd0);
    write_reg(dva_pkg::REG_DEN_FLOOR, 32'hFFFF_FFFF);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'd1, 32'd1, 32'd1, 16'hFFFE, 12'd0);
    send_item(COMMAND_DEPOSIT, 32'd9, 32'd1, 32'd1, 32'd1, 16'hFFFF, 12'd0);
  endtask

  // Unit bins and density with maximal energy drive a voxel into saturation.
  task automatic test_saturation();
    setup_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1);
    repeat (3)
      send_item(COMMAND_DEPOSIT, '1, 32'h8000_0000, 32'h8000_000F, 32'h8000_0007,
                16'd1, 12'd0);
    send_item(COMMAND_READ, 0, 0, 0, 0, 0, 12'h0F7);
    send_item(COMMAND_DEPOSIT, '1, 32'h8000_0010, 32'h8000_0000, 32'h8000_0000,
              16'd1, 12'd0);
  endtask

  task automatic test_random_phase(input int count);
    repeat (count) send_random_item();
  endtask

  // The receiver holds off while items keep being offered, then the sender
  // waits for every result before going on.
  task automatic test_backpressure();
    hold_cycles = 600;
    repeat (6) send_random_item();
    wait_drained();
    quiet_receiver = 1'b1;
    repeat (40) send_random_item();
    quiet_receiver = 1'b0;
  endtask

  // Receiver stall pattern: changes character after a random run of cycles.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 400);
      end
      left--;
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (quiet_receiver || mode == 0)
        out_stall <= 1'b0;
      else if (mode == 1)
        out_stall <= ($urandom_range(0, 99) < 30);
      else if (mode == 2)
        out_stall <= ($urandom_range(0, 99) < 85);
      else
        out_stall <= ((left / 7) % 2 == 1);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    dose_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: status %0d voxel %0d dose %h", out_status,
                   out_voxel_index, out_dose_value);
      end else begin
        want = pending_results.pop_front();
        if (want.status == dva_pkg::ST_DEPOSIT) deposits_seen++;
        if (want.status != dva_pkg::ST_READ && want.dose == '1) saturated_seen++;
        if (out_status !== want.status || out_voxel_index !== want.voxel ||
            out_dose_value !== want.dose) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: status %0d/%0d voxel %0d/%0d dose %h/%h",
                     $realtime, out_status, want.status, out_voxel_index, want.voxel,
                     out_dose_value, want.dose);
        end
      end
    end
  end

  // Run time limit.
  initial begin
    #60ms;
    $display("[dose_voxel_accumulator] ERROR");
    $finish;
  end

  initial begin
    grid_origin = '{0, 0, 0};
    grid_bin = '{13'd16, 13'd16, 13'd16};
    vacuum_floor = 16'd1;
    foreach (voxel_dose[i]) voxel_dose[i] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_special_cases();
    test_saturation();
    setup_grid(32'd0, 32'd0, 32'd0, 16, 16, 16, 1);
    test_random_phase(400);
    setup_grid(32'h7FFF_FF00, 32'hFFFF_FFC0, 32'h8000_0000, 1, 4, 2, 0);
    test_random_phase(300);
    test_backpressure();
    setup_grid($urandom, $urandom, $urandom, 8191, 4096, 13'h1000, 65535);
    test_random_phase(200);
    setup_grid($urandom, $urandom, $urandom, $urandom_range(1, 40),
               $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 2000));
    test_random_phase(400);
    setup_grid(32'hFFFF_F000, 32'd100, 32'd0, 8191, 3, 1, 32'd10);
    test_random_phase(300);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d items over seven grid setups; %0d results checked, %0d deposits,",
             items_sent, results_seen, deposits_seen);
    $display("%0d saturated sums, %0d mismatches.", saturated_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[dose_voxel_accumulator] OK");
    else
      $display("[dose_voxel_accumulator] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
